@@ rtl/hlpc_pkg.sv @@
// ============================================================================
// hlpc_pkg
// Shared types and constants for the hopping leg phase controller.
// ============================================================================
package hlpc_pkg;

    // Default control tick length in milliseconds.
    localparam int unsigned TICK_MS_DEFAULT = 1;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_REST_LENGTH     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_FRAC  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPRING_STIFF    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_THRUST_FORCE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_POSE_GAIN_P     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_POSE_GAIN_V     = 3'd5;

    // Configuration reset values.
    localparam logic [15:0] REST_LENGTH_RST    = 16'd4915;
    localparam logic [15:0] THRESHOLD_FRAC_RST = 16'd62259;
    localparam logic [15:0] SPRING_STIFF_RST   = 16'd2000;
    localparam logic [15:0] THRUST_FORCE_RST   = 16'd1600;
    localparam logic [15:0] POSE_GAIN_P_RST    = 16'd3277;
    localparam logic [15:0] POSE_GAIN_V_RST    = 16'd102;

    // Leg length assumed before the first tick (0.8 m in Q4.12).
    localparam logic [15:0] PRIOR_LENGTH_RST = 16'd3277;

    // Width of the scaled absolute difference and of the signed raw rate.
    localparam int SCALED_W = 26;
    localparam int RAW_W    = SCALED_W + 1;

    // Hop phases.
    typedef enum logic [2:0] {
        PH_LOADING     = 3'd0,
        PH_COMPRESSION = 3'd1,
        PH_THRUST      = 3'd2,
        PH_UNLOADING   = 3'd3,
        PH_FLIGHT      = 3'd4
    } phase_t;

    // Stage enables for the rate scaling pipeline.
    typedef struct packed {
        logic mul;
        logic fix;
    } scale_en_t;

endpackage

@@ rtl/hlpc_rate_scale.sv @@
// ============================================================================
// hlpc_rate_scale
// Two-stage scaling of an absolute difference (already times 1000) by
// 1/TICK_MS with truncation, followed by the sign of the difference.
// ============================================================================
module hlpc_rate_scale #(
    parameter int unsigned TICK_MS = hlpc_pkg::TICK_MS_DEFAULT
) (
    input  logic                                  clk,
    input  hlpc_pkg::scale_en_t                   en,
    input  logic [hlpc_pkg::SCALED_W-1:0]         scaled,
    input  logic                                  neg,
    output logic signed [hlpc_pkg::RAW_W-1:0]     raw
);
    import hlpc_pkg::*;

    // Reciprocal with 31 fraction bits; the estimate is low by at most one.
    localparam int          RECIP_SHIFT = 31;
    localparam logic [31:0] RECIP       = 32'((64'd1 << RECIP_SHIFT) / TICK_MS);
    localparam logic [RAW_W-1:0] TICK_W = RAW_W'(TICK_MS);

    logic [SCALED_W+31:0]  product;
    logic [SCALED_W-1:0]   est_next;
    logic [SCALED_W-1:0]   est_reg;
    logic [SCALED_W-1:0]   scaled_reg;
    logic                  neg_reg;
    logic [RAW_W-1:0]      back_mul;
    logic [RAW_W-1:0]      remainder;
    logic [SCALED_W-1:0]   quot;
    logic signed [RAW_W-1:0] raw_next;
    logic signed [RAW_W-1:0] raw_reg;

    assign product  = {32'd0, scaled} * {{SCALED_W{1'b0}}, RECIP};
    assign est_next = product[SCALED_W+RECIP_SHIFT-1:RECIP_SHIFT];

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            est_reg    <= est_next;
            scaled_reg <= scaled;
            neg_reg    <= neg;
        end
    end

    // The remainder is known to lie below twice the tick, so one compare
    // settles the quotient.
    assign back_mul  = RAW_W'({1'b0, est_reg} * TICK_W);
    assign remainder = {1'b0, scaled_reg} - back_mul;
    assign quot      = est_reg + SCALED_W'(remainder >= TICK_W);
    assign raw_next  = neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    always_ff @(posedge clk)
    begin
        if (en.fix)
        begin
            raw_reg <= raw_next;
        end
    end

    assign raw = raw_reg;

endmodule

@@ rtl/hopping_leg_phase_controller_unit.sv @@
// ============================================================================
// hopping_leg_phase_controller_unit
// Stance controller for a single hopping leg: phase machine, spring force
// and attitude PD hip torques, one request per control tick.
// ============================================================================
// Usage:
// Each input request is one control tick (leg length, foot contact, roll and
// pitch). It is taken at a clock edge where in_valid is high and in_stall is
// low. Each request yields exactly one result request on the output channel,
// taken where out_valid is high and out_stall is low.
// The datapath is a seven-register pipeline. The edge that takes a request
// loads the first register; the request then moves through stages two to six
// into the output register, where out_valid rises. One request is accepted
// every cycle while in_stall is low; the rate is set by the filter, phase and
// stance-timer update in stage five, which all happen in the same cycle.
// When the receiver stalls, results stay in the output register and empty
// stages ahead of it keep filling; in_stall rises only once every stage holds
// a request.
// Configuration registers are written over the cfg channel (always ready) and
// may only be changed while no request is in flight.
// Reset clears the pipeline, returns the configuration to its defaults and
// puts the hop machine in thrust with all rates and timers at zero.
// ============================================================================
module hopping_leg_phase_controller_unit #(
    parameter int unsigned TICK_MS = hlpc_pkg::TICK_MS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hlpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [15:0]                          cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [15:0]                          leg_length,
    input  logic                                 foot_contact,
    input  logic signed [15:0]                   roll_angle,
    input  logic signed [15:0]                   pitch_angle,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [2:0]                           hop_phase,
    output logic signed [31:0]                   spring_force,
    output logic signed [23:0]                   hip_torque_x,
    output logic signed [23:0]                   hip_torque_z,
    output logic                                 torque_active,
    output logic [15:0]                          stance_duration_ms
);
    import hlpc_pkg::*;

    localparam logic [16:0] TICK_STEP = 17'(TICK_MS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] rest_length_reg;
    logic [15:0] threshold_frac_reg;
    logic [15:0] spring_stiff_reg;
    logic [15:0] thrust_force_reg;
    logic [15:0] pose_gain_p_reg;
    logic [15:0] pose_gain_v_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_length_reg    <= REST_LENGTH_RST;
            threshold_frac_reg <= THRESHOLD_FRAC_RST;
            spring_stiff_reg   <= SPRING_STIFF_RST;
            thrust_force_reg   <= THRUST_FORCE_RST;
            pose_gain_p_reg    <= POSE_GAIN_P_RST;
            pose_gain_v_reg    <= POSE_GAIN_V_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // Indexes past the last register are dropped.
            case (cfg_index)
                REG_REST_LENGTH:    rest_length_reg    <= cfg_data;
                REG_THRESHOLD_FRAC: threshold_frac_reg <= cfg_data;
                REG_SPRING_STIFF:   spring_stiff_reg   <= cfg_data;
                REG_THRUST_FORCE:   thrust_force_reg   <= cfg_data;
                REG_POSE_GAIN_P:    pose_gain_p_reg    <= cfg_data;
                REG_POSE_GAIN_V:    pose_gain_v_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. A stage loads when it is empty or when the
    // stage after it loads, so bubbles collapse while the output stalls.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, out_valid_reg;
    logic en1, en2, en3, en4, en5, en6, en7;
    logic accept;
    logic step;

    assign en7      = !out_valid_reg || !out_stall;
    assign en6      = !v6_reg || en7;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;
    assign accept   = in_valid && en1;
    assign step     = v4_reg && en5;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg        <= in_valid;
            if (en2) v2_reg        <= v1_reg;
            if (en3) v3_reg        <= v2_reg;
            if (en4) v4_reg        <= v3_reg;
            if (en5) v5_reg        <= v4_reg;
            if (en6) v6_reg        <= v5_reg;
            if (en7) out_valid_reg <= v6_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: differences against the previously accepted tick.
    // ------------------------------------------------------------------
    logic [15:0]        prior_len_reg;
    logic signed [15:0] prior_roll_reg;
    logic signed [15:0] prior_pitch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_len_reg   <= PRIOR_LENGTH_RST;
            prior_roll_reg  <= '0;
            prior_pitch_reg <= '0;
        end
        else if (accept)
        begin
            prior_len_reg   <= leg_length;
            prior_roll_reg  <= roll_angle;
            prior_pitch_reg <= pitch_angle;
        end
    end

    logic [15:0]        s1_len_reg;
    logic               s1_contact_reg;
    logic signed [15:0] s1_roll_reg;
    logic signed [15:0] s1_pitch_reg;
    logic signed [16:0] s1_dlen_reg;
    logic signed [16:0] s1_droll_reg;
    logic signed [16:0] s1_dpitch_reg;
    logic signed [16:0] dlen_next;
    logic signed [16:0] droll_next;
    logic signed [16:0] dpitch_next;

    assign dlen_next   = $signed({1'b0, leg_length}) - $signed({1'b0, prior_len_reg});
    assign droll_next  = 17'(roll_angle) - 17'(prior_roll_reg);
    assign dpitch_next = 17'(pitch_angle) - 17'(prior_pitch_reg);

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_len_reg     <= leg_length;
            s1_contact_reg <= foot_contact;
            s1_roll_reg    <= roll_angle;
            s1_pitch_reg   <= pitch_angle;
            s1_dlen_reg    <= dlen_next;
            s1_droll_reg   <= droll_next;
            s1_dpitch_reg  <= dpitch_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitudes times 1000, threshold compares, spring product.
    // ------------------------------------------------------------------
    function automatic logic [SCALED_W-1:0] scale_abs(input logic signed [16:0] d);
        logic [16:0] mag;
        mag = d[16] ? 17'(-d) : 17'(d);
        return SCALED_W'({{(SCALED_W-16){1'b0}}, mag[15:0]} * SCALED_W'(1000));
    endfunction

    logic [31:0]        threshold;
    logic [31:0]        len_scaled;
    logic signed [16:0] compression;
    logic signed [33:0] fbase_next;

    assign threshold   = {16'd0, rest_length_reg} * {16'd0, threshold_frac_reg};
    assign len_scaled  = {s1_len_reg, 16'd0};
    assign compression = $signed({1'b0, rest_length_reg}) - $signed({1'b0, s1_len_reg});
    assign fbase_next  = 34'(compression) * 34'($signed({1'b0, spring_stiff_reg}));

    logic [SCALED_W-1:0] s2_ylen_reg, s2_yroll_reg, s2_ypitch_reg;
    logic                s2_nlen_reg, s2_nroll_reg, s2_npitch_reg;
    logic                s2_below_reg, s2_above_reg, s2_contact_reg;
    logic signed [33:0]  s2_fbase_reg;
    logic signed [15:0]  s2_roll_reg, s2_pitch_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_ylen_reg    <= scale_abs(s1_dlen_reg);
            s2_yroll_reg   <= scale_abs(s1_droll_reg);
            s2_ypitch_reg  <= scale_abs(s1_dpitch_reg);
            s2_nlen_reg    <= s1_dlen_reg[16];
            s2_nroll_reg   <= s1_droll_reg[16];
            s2_npitch_reg  <= s1_dpitch_reg[16];
            s2_below_reg   <= len_scaled < threshold;
            s2_above_reg   <= len_scaled > threshold;
            s2_contact_reg <= s1_contact_reg;
            s2_fbase_reg   <= fbase_next;
            s2_roll_reg    <= s1_roll_reg;
            s2_pitch_reg   <= s1_pitch_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages 3 and 4: divide by the tick length (one scaler per
    // axis); the angle terms of the PD law are formed alongside.
    // ------------------------------------------------------------------
    scale_en_t               scale_en;
    logic signed [RAW_W-1:0] raw_len, raw_roll, raw_pitch;

    assign scale_en = '{mul: en3, fix: en4};

    hlpc_rate_scale #(.TICK_MS(TICK_MS)) u_scale_len (
        .clk    (clk),
        .en     (scale_en),
        .scaled (s2_ylen_reg),
        .neg    (s2_nlen_reg),
        .raw    (raw_len)
    );

    hlpc_rate_scale #(.TICK_MS(TICK_MS)) u_scale_roll (
        .clk    (clk),
        .en     (scale_en),
        .scaled (s2_yroll_reg),
        .neg    (s2_nroll_reg),
        .raw    (raw_roll)
    );

    hlpc_rate_scale #(.TICK_MS(TICK_MS)) u_scale_pitch (
        .clk    (clk),
        .en     (scale_en),
        .scaled (s2_ypitch_reg),
        .neg    (s2_npitch_reg),
        .raw    (raw_pitch)
    );

    logic signed [16:0] gain_p;
    logic signed [32:0] ppx_next, ppz_next;

    assign gain_p   = $signed({1'b0, pose_gain_p_reg});
    assign ppx_next = 33'(gain_p) * 33'(s2_roll_reg);
    assign ppz_next = 33'(gain_p) * 33'(s2_pitch_reg);

    logic               s3_below_reg, s3_above_reg, s3_contact_reg;
    logic signed [33:0] s3_fbase_reg;
    logic signed [32:0] s3_ppx_reg, s3_ppz_reg;
    logic               s4_below_reg, s4_above_reg, s4_contact_reg;
    logic signed [33:0] s4_fbase_reg;
    logic signed [32:0] s4_ppx_reg, s4_ppz_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_below_reg   <= s2_below_reg;
            s3_above_reg   <= s2_above_reg;
            s3_contact_reg <= s2_contact_reg;
            s3_fbase_reg   <= s2_fbase_reg;
            s3_ppx_reg     <= ppx_next;
            s3_ppz_reg     <= ppz_next;
        end
        if (en4)
        begin
            s4_below_reg   <= s3_below_reg;
            s4_above_reg   <= s3_above_reg;
            s4_contact_reg <= s3_contact_reg;
            s4_fbase_reg   <= s3_fbase_reg;
            s4_ppx_reg     <= s3_ppx_reg;
            s4_ppz_reg     <= s3_ppz_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: the feedback loop. Rates are filtered, the hop machine steps
    // and the stance timer runs, all in the same cycle so the next tick sees them.
    // ------------------------------------------------------------------
    logic signed [31:0] len_rate_reg, roll_rate_reg, pitch_rate_reg;
    logic signed [31:0] len_rate_next, roll_rate_next, pitch_rate_next;
    phase_t             phase_reg, phase_next;
    logic               prior_contact_reg;
    logic [15:0]        stance_timer_reg, stance_timer_next;
    logic [15:0]        last_stance_reg, last_stance_next;
    logic [16:0]        timer_sum;
    logic signed [31:0] force_next;
    logic signed [28:0] force_spring;

    // Halving low-pass filter: floor((old + raw) / 2). The sum never leaves
    // the 32-bit range after the halving, so no clamp is needed.
    function automatic logic signed [31:0] filter_rate(input logic signed [31:0] old,
                                                       input logic signed [RAW_W-1:0] raw);
        logic signed [32:0] sum;
        sum = 33'(old) + 33'(raw);
        return 32'(sum >>> 1);
    endfunction

    assign len_rate_next   = filter_rate(len_rate_reg, raw_len);
    assign roll_rate_next  = filter_rate(roll_rate_reg, raw_roll);
    assign pitch_rate_next = filter_rate(pitch_rate_reg, raw_pitch);

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_LOADING:
            begin
                if (s4_below_reg) phase_next = PH_COMPRESSION;
            end
            PH_COMPRESSION:
            begin
                if (len_rate_next > 0) phase_next = PH_THRUST;
            end
            PH_THRUST:
            begin
                if (s4_above_reg) phase_next = PH_UNLOADING;
            end
            PH_UNLOADING:
            begin
                if (!s4_contact_reg) phase_next = PH_FLIGHT;
            end
            PH_FLIGHT:
            begin
                if (s4_contact_reg) phase_next = PH_LOADING;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // A touchdown restarts the stance timer; otherwise it counts up and
    // saturates. Liftoff latches the finished stance.
    assign timer_sum = {1'b0, stance_timer_reg} + TICK_STEP;

    always_comb
    begin
        if (!prior_contact_reg && s4_contact_reg)
        begin
            stance_timer_next = '0;
        end
        else if (timer_sum[16])
        begin
            stance_timer_next = '1;
        end
        else
        begin
            stance_timer_next = timer_sum[15:0];
        end
        if (prior_contact_reg && !s4_contact_reg)
        begin
            last_stance_next = stance_timer_next;
        end
        else
        begin
            last_stance_next = last_stance_reg;
        end
    end

    // Spring force in Q23.8: the product fits in 34 bits, so after the
    // floor shift plus the thrust term it always stays inside 32 bits.
    assign force_spring = 29'(s4_fbase_reg >>> 4);
    assign force_next   = 32'(force_spring)
                        + ((phase_next == PH_THRUST) ? $signed({12'd0, thrust_force_reg, 4'd0})
                                                     : 32'sd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_rate_reg      <= '0;
            roll_rate_reg     <= '0;
            pitch_rate_reg    <= '0;
            phase_reg         <= PH_THRUST;
            prior_contact_reg <= 1'b0;
            stance_timer_reg  <= '0;
            last_stance_reg   <= '0;
        end
        else if (step)
        begin
            len_rate_reg      <= len_rate_next;
            roll_rate_reg     <= roll_rate_next;
            pitch_rate_reg    <= pitch_rate_next;
            phase_reg         <= phase_next;
            prior_contact_reg <= s4_contact_reg;
            stance_timer_reg  <= stance_timer_next;
            last_stance_reg   <= last_stance_next;
        end
    end

    phase_t             s5_phase_reg;
    logic signed [31:0] s5_force_reg;
    logic [15:0]        s5_stance_reg;
    logic signed [31:0] s5_roll_rate_reg, s5_pitch_rate_reg;
    logic signed [32:0] s5_ppx_reg, s5_ppz_reg;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_phase_reg      <= phase_next;
            s5_force_reg      <= force_next;
            s5_stance_reg     <= last_stance_next;
            s5_roll_rate_reg  <= roll_rate_next;
            s5_pitch_rate_reg <= pitch_rate_next;
            s5_ppx_reg        <= s4_ppx_reg;
            s5_ppz_reg        <= s4_ppz_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: rate terms of the PD law.
    // ------------------------------------------------------------------
    logic signed [16:0] gain_v;
    logic signed [48:0] pvx_next, pvz_next;

    assign gain_v   = $signed({1'b0, pose_gain_v_reg});
    assign pvx_next = 49'(gain_v) * 49'(s5_roll_rate_reg);
    assign pvz_next = 49'(gain_v) * 49'(s5_pitch_rate_reg);

    phase_t             s6_phase_reg;
    logic signed [31:0] s6_force_reg;
    logic [15:0]        s6_stance_reg;
    logic signed [32:0] s6_ppx_reg, s6_ppz_reg;
    logic signed [48:0] s6_pvx_reg, s6_pvz_reg;

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            s6_phase_reg  <= s5_phase_reg;
            s6_force_reg  <= s5_force_reg;
            s6_stance_reg <= s5_stance_reg;
            s6_ppx_reg    <= s5_ppx_reg;
            s6_ppz_reg    <= s5_ppz_reg;
            s6_pvx_reg    <= pvx_next;
            s6_pvz_reg    <= pvz_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: sum, floor to Q11.12, saturate, gate by phase.
    // ------------------------------------------------------------------
    function automatic logic signed [23:0] pd_torque(input logic signed [32:0] pterm,
                                                     input logic signed [48:0] vterm);
        logic signed [48:0] sum;
        logic signed [48:0] shifted;
        sum     = 49'(pterm) + vterm;
        shifted = sum >>> 12;
        if (shifted > 49'sd8388607)
        begin
            return 24'sh7FFFFF;
        end
        else if (shifted < -49'sd8388608)
        begin
            return 24'sh800000;
        end
        return 24'(shifted);
    endfunction

    logic               drive;
    logic               active_next;
    logic signed [23:0] tx_next, tz_next;

    always_comb
    begin
        drive       = 1'b0;
        active_next = 1'b0;
        case (s6_phase_reg)
            PH_COMPRESSION, PH_THRUST:
            begin
                drive       = 1'b1;
                active_next = 1'b1;
            end
            PH_LOADING, PH_UNLOADING:
            begin
                active_next = 1'b1;
            end
            default:
            begin
                // Flight (and codes that never arise) leave the hips undriven.
                active_next = 1'b0;
            end
        endcase
        tx_next = drive ? pd_torque(s6_ppx_reg, s6_pvx_reg) : 24'sd0;
        tz_next = drive ? pd_torque(s6_ppz_reg, s6_pvz_reg) : 24'sd0;
    end

    phase_t             out_phase_reg;
    logic signed [31:0] out_force_reg;
    logic signed [23:0] out_tx_reg, out_tz_reg;
    logic               out_active_reg;
    logic [15:0]        out_stance_reg;

    always_ff @(posedge clk)
    begin
        if (en7)
        begin
            out_phase_reg  <= s6_phase_reg;
            out_force_reg  <= s6_force_reg;
            out_tx_reg     <= tx_next;
            out_tz_reg     <= tz_next;
            out_active_reg <= active_next;
            out_stance_reg <= s6_stance_reg;
        end
    end

    assign hop_phase          = out_phase_reg;
    assign spring_force       = out_force_reg;
    assign hip_torque_x       = out_tx_reg;
    assign hip_torque_z       = out_tz_reg;
    assign torque_active      = out_active_reg;
    assign stance_duration_ms = out_stance_reg;

endmodule

@@ tb/hop_result_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hop_result_checker
// Watches the configuration, tick and result channels of the hopping leg
// controller. It keeps its own copy of the controller state, predicts the
// result of every accepted tick and compares each accepted result with it.
// ============================================================================
module hop_result_checker #(
    parameter int unsigned TICK_MS = hlpc_pkg::TICK_MS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [hlpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [15:0]                       cfg_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [15:0]                       leg_length,
    input  logic                              foot_contact,
    input  logic signed [15:0]                roll_angle,
    input  logic signed [15:0]                pitch_angle,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [2:0]                        hop_phase,
    input  logic signed [31:0]                spring_force,
    input  logic signed [23:0]                hip_torque_x,
    input  logic signed [23:0]                hip_torque_z,
    input  logic                              torque_active,
    input  logic [15:0]                       stance_duration_ms,
    output int                                fail_count,
    output int                                pending
);
    import hlpc_pkg::*;

    localparam longint I32_MIN = -64'sd2147483648;
    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint T24_MIN = -64'sd8388608;
    localparam longint T24_MAX = 64'sd8388607;
    localparam int unsigned TIMER_MAX = 65535;

    typedef struct packed {
        phase_t             hop_phase;
        logic signed [31:0] spring_force;
        logic signed [23:0] torque_x;
        logic signed [23:0] torque_z;
        logic               torque_active;
        logic [15:0]        stance_ms;
    } hop_result_t;

    // Register copies.
    logic [15:0] rest_len   = REST_LENGTH_RST;
    logic [15:0] thr_frac   = THRESHOLD_FRAC_RST;
    logic [15:0] stiffness  = SPRING_STIFF_RST;
    logic [15:0] thrust_add = THRUST_FORCE_RST;
    logic [15:0] gain_p     = POSE_GAIN_P_RST;
    logic [15:0] gain_v     = POSE_GAIN_V_RST;

    // Controller state copy.
    logic [15:0] last_len     = PRIOR_LENGTH_RST;
    int          len_rate     = 0;
    int          last_roll    = 0;
    int          last_pitch   = 0;
    int          roll_rate    = 0;
    int          pitch_rate   = 0;
    phase_t      hop_state    = PH_THRUST;
    logic        last_contact = 1'b0;
    int unsigned timer_ms     = 0;
    int unsigned stance_ms    = 0;

    hop_result_t due_results[$];
    int          mismatches = 0;
    int          due_count  = 0;

    assign fail_count = mismatches;
    assign pending    = due_count;

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Differentiate, scale to per-second units and average with the old rate.
    function automatic int filtered_rate(int old_rate, longint diff);
        longint raw;
        raw = diff * 1000 / longint'(TICK_MS);
        return int'(clamp_range((longint'(old_rate) + raw) >>> 1, I32_MIN, I32_MAX));
    endfunction

    function automatic longint attitude_torque(int angle, int rate);
        longint t;
        t = longint'(gain_p) * longint'(angle) + longint'(gain_v) * longint'(rate);
        return clamp_range(t >>> 12, T24_MIN, T24_MAX);
    endfunction

    // Advances the state copy by one tick and returns the result it causes.
    function automatic hop_result_t predict_tick(logic [15:0] len, logic contact,
                                                 logic signed [15:0] roll,
                                                 logic signed [15:0] pitch);
        longint      thr;
        longint      len_scaled;
        longint      spring;
        hop_result_t r;
        thr        = longint'(rest_len) * longint'(thr_frac);
        len_scaled = longint'(len) * 65536;

        len_rate   = filtered_rate(len_rate, longint'(len) - longint'(last_len));
        last_len   = len;
        roll_rate  = filtered_rate(roll_rate, longint'(roll) - longint'(last_roll));
        last_roll  = roll;
        pitch_rate = filtered_rate(pitch_rate, longint'(pitch) - longint'(last_pitch));
        last_pitch = pitch;

        if (!last_contact && contact)
            timer_ms = 0;
        else if (timer_ms + TICK_MS > TIMER_MAX)
            timer_ms = TIMER_MAX;
        else
            timer_ms = timer_ms + TICK_MS;
        if (last_contact && !contact)
            stance_ms = timer_ms;
        last_contact = contact;

        case (hop_state)
            PH_LOADING:     if (len_scaled < thr) hop_state = PH_COMPRESSION;
            PH_COMPRESSION: if (len_rate > 0) hop_state = PH_THRUST;
            PH_THRUST:      if (len_scaled > thr) hop_state = PH_UNLOADING;
            PH_UNLOADING:   if (!contact) hop_state = PH_FLIGHT;
            PH_FLIGHT:      if (contact) hop_state = PH_LOADING;
            default:        ;
        endcase

        spring = ((longint'(rest_len) - longint'(len)) * longint'(stiffness)) >>> 4;
        if (hop_state == PH_THRUST)
            spring = spring + longint'(thrust_add) * 16;

        r.hop_phase     = hop_state;
        r.spring_force  = 32'(clamp_range(spring, I32_MIN, I32_MAX));
        r.torque_x      = '0;
        r.torque_z      = '0;
        r.torque_active = 1'b1;
        if (hop_state == PH_COMPRESSION || hop_state == PH_THRUST) begin
            r.torque_x = 24'(attitude_torque(roll, roll_rate));
            r.torque_z = 24'(attitude_torque(pitch, pitch_rate));
        end else if (hop_state != PH_LOADING && hop_state != PH_UNLOADING) begin
            r.torque_active = 1'b0;
        end
        r.stance_ms = stance_ms[15:0];
        return r;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk) begin : watch
        hop_result_t want;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_REST_LENGTH:    rest_len   = cfg_data;
                    REG_THRESHOLD_FRAC: thr_frac   = cfg_data;
                    REG_SPRING_STIFF:   stiffness  = cfg_data;
                    REG_THRUST_FORCE:   thrust_add = cfg_data;
                    REG_POSE_GAIN_P:    gain_p     = cfg_data;
                    REG_POSE_GAIN_V:    gain_v     = cfg_data;
                    default:            ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result mismatch, expected no result, actual phase %0d",
                             $time, hop_phase);
                end else begin
                    want = due_results.pop_front();
                    check_field("hop_phase", longint'(want.hop_phase), longint'(hop_phase));
                    check_field("spring_force", longint'(want.spring_force),
                                longint'(spring_force));
                    check_field("hip_torque_x", longint'(want.torque_x), longint'(hip_torque_x));
                    check_field("hip_torque_z", longint'(want.torque_z), longint'(hip_torque_z));
                    check_field("torque_active", longint'(want.torque_active),
                                longint'(torque_active));
                    check_field("stance_duration_ms", longint'(want.stance_ms),
                                longint'(stance_duration_ms));
                end
            end
            if (in_valid && !in_stall)
                due_results.push_back(predict_tick(leg_length, foot_contact,
                                                   roll_angle, pitch_angle));
        end
        due_count <= due_results.size();
    end

endmodule

@@ tb/tb_hopping_leg_phase_controller_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_hopping_leg_phase_controller_unit
// Drives control ticks and configuration writes into the hopping leg phase
// controller with random gaps and back-pressure, and reports the verdict of
// the result checker that runs beside it.
// ============================================================================
module tb_hopping_leg_phase_controller_unit;
    import hlpc_pkg::*;

    localparam int unsigned TICK_MS     = TICK_MS_DEFAULT;
    localparam int          CYCLE_LIMIT = 1000000;
    // Indexes past the last register; writes to them must leave every register alone.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [15:0]            cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [15:0]            leg_length;
    logic                   foot_contact;
    logic signed [15:0]     roll_angle;
    logic signed [15:0]     pitch_angle;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [2:0]             hop_phase;
    logic signed [31:0]     spring_force;
    logic signed [23:0]     hip_torque_x;
    logic signed [23:0]     hip_torque_z;
    logic                   torque_active;
    logic [15:0]            stance_duration_ms;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int unsigned tick_count  = 0;
    // Threshold inputs as last written, so that the random hops can aim at the
    // switching length of the current setting.
    int unsigned cur_rest;
    int unsigned cur_frac;
    // When set, the sender or the receiver runs without any idle cycles.
    bit          tx_quiet;
    bit          rx_quiet;
    int unsigned rx_hold = 0;
    int          roll_walk  = 0;
    int          pitch_walk = 0;

    hopping_leg_phase_controller_unit #(
        .TICK_MS(TICK_MS)
    ) u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .leg_length         (leg_length),
        .foot_contact       (foot_contact),
        .roll_angle         (roll_angle),
        .pitch_angle        (pitch_angle),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .hop_phase          (hop_phase),
        .spring_force       (spring_force),
        .hip_torque_x       (hip_torque_x),
        .hip_torque_z       (hip_torque_z),
        .torque_active      (torque_active),
        .stance_duration_ms (stance_duration_ms)
    );

    hop_result_checker #(
        .TICK_MS(TICK_MS)
    ) u_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .leg_length         (leg_length),
        .foot_contact       (foot_contact),
        .roll_angle         (roll_angle),
        .pitch_angle        (pitch_angle),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .hop_phase          (hop_phase),
        .spring_force       (spring_force),
        .hip_torque_x       (hip_torque_x),
        .hip_torque_z       (hip_torque_z),
        .torque_active      (torque_active),
        .stance_duration_ms (stance_duration_ms),
        .fail_count         (fail_count),
        .pending            (pending)
    );

    // 12 ns clock period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog. The slowest correct run is far below this limit, so reaching it
    // means the block has stopped answering.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Most idle stretches are short, a few are long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver back-pressure. A new stall burst is only drawn once the last one has
    // run out and out_stall is lowered, so out_stall gets a single assignment per clock edge.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (rx_hold > 0) begin
            out_stall <= 1'b1;
            rx_hold = rx_hold - 1;
        end else begin
            out_stall <= 1'b0;
            if (!rx_quiet && $urandom_range(0, 3) == 0)
                rx_hold = pick_gap();
        end
    end

    function automatic longint clamp_len(longint v);
        return (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
    endfunction

    // Body angles follow a slow random walk, with an occasional jump anywhere
    // in the signed range.
    function automatic int next_angle(int a);
        if ($urandom_range(0, 19) == 0)
            return int'($urandom_range(0, 65535)) - 32768;
        a = a + int'($urandom_range(0, 400)) - 200;
        return (a < -32768) ? -32768 : ((a > 32767) ? 32767 : a);
    endfunction

    // Sends one tick request. The request is held, payload and all, until the
    // block takes it. An optional idle gap comes first; when the next request
    // follows directly, in_valid simply stays high.
    task automatic send_tick(longint len, bit contact, int roll, int pitch);
        int unsigned gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        leg_length   <= 16'(len);
        foot_contact <= contact;
        roll_angle   <= 16'(roll);
        pitch_angle  <= 16'(pitch);
        @(posedge clk);
        while (in_stall) @(posedge clk);
        tick_count = tick_count + 1;
    endtask

    // One configuration write. The channel is lowered again before the task returns
    // so that back-to-back writes never assign cfg_valid twice in a step.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (index == REG_REST_LENGTH)
            cur_rest = data;
        if (index == REG_THRESHOLD_FRAC)
            cur_frac = data;
        @(posedge clk);
    endtask

    task automatic load_config(logic [15:0] rest, logic [15:0] frac, logic [15:0] stiff,
                               logic [15:0] thrust, logic [15:0] kp, logic [15:0] kv);
        write_reg(REG_REST_LENGTH, rest);
        write_reg(REG_THRESHOLD_FRAC, frac);
        write_reg(REG_SPRING_STIFF, stiff);
        write_reg(REG_THRUST_FORCE, thrust);
        write_reg(REG_POSE_GAIN_P, kp);
        write_reg(REG_POSE_GAIN_V, kv);
    endtask

    // The sender holds off until every request in flight has produced its
    // result. Each tick yields exactly one result, so the block is idle then
    // and the registers may be changed.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Random part. Most of the traffic is well-formed hops: a stance in which
    // the leg compresses below the switching length and extends past it again,
    // followed by a short flight. Some stances lose contact early, and the rest
    // of the traffic is unconstrained noise that reaches every input bit.
    task automatic run_hops(int unsigned count);
        int unsigned stop_at;
        int          stance;
        int          half;
        int          drop_at;
        longint      thr;
        longint      depth;
        longint      offs;
        stop_at = tick_count + count;
        while (tick_count < stop_at) begin
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_tick($urandom_range(0, 65535), 1'($urandom_range(0, 1)),
                              $urandom_range(0, 65535), $urandom_range(0, 65535));
            end else begin
                thr     = (longint'(cur_rest) * longint'(cur_frac)) >>> 16;
                depth   = $urandom_range(1, 1500);
                stance  = $urandom_range(4, 16);
                half    = stance / 2;
                drop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, stance - 1) : stance;
                // Lengths run down from above the threshold to below it over
                // the first half of the stance and back up over the second.
                for (int k = 0; k < stance; k++) begin
                    if (k < half)
                        offs = depth - (2 * depth * k) / half;
                    else
                        offs = (2 * depth * (k - half + 1)) / (stance - half) - depth;
                    roll_walk  = next_angle(roll_walk);
                    pitch_walk = next_angle(pitch_walk);
                    send_tick(clamp_len(thr + offs), (k < drop_at), roll_walk, pitch_walk);
                end
                repeat ($urandom_range(1, 6)) begin
                    roll_walk  = next_angle(roll_walk);
                    pitch_walk = next_angle(pitch_walk);
                    send_tick(clamp_len(thr + depth + longint'($urandom_range(0, 300))), 1'b0,
                              roll_walk, pitch_walk);
                end
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        leg_length   = '0;
        foot_contact = 1'b0;
        roll_angle   = '0;
        pitch_angle  = '0;
        cur_rest     = REST_LENGTH_RST;
        cur_frac     = THRESHOLD_FRAC_RST;
        tx_quiet     = 1'b0;
        rx_quiet     = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks on the reset settings. The machine starts in thrust,
        // is walked through unloading, flight, loading and compression back to
        // thrust, with contact edges and the extremes of every field on the way.
        send_tick(3277, 1'b1, 0, 0);
        send_tick(4000, 1'b1, 32767, -32768);
        send_tick(65535, 1'b1, -32768, 32767);
        send_tick(5000, 1'b1, 100, -100);
        send_tick(5000, 1'b0, 0, 0);
        send_tick(0, 1'b0, -32768, -32768);
        send_tick(4000, 1'b1, 32767, 32767);
        send_tick(4600, 1'b1, 0, 0);
        send_tick(4500, 1'b1, 1000, -1000);
        send_tick(4000, 1'b1, -1000, 1000);
        send_tick(3000, 1'b1, 32767, -32768);
        send_tick(2000, 1'b1, -32768, 32767);
        send_tick(2500, 1'b1, 0, 0);
        send_tick(0, 1'b1, 32767, 32767);
        send_tick(65535, 1'b1, -32768, -32768);
        send_tick(65535, 1'b0, 0, 0);
        send_tick(65535, 1'b1, 0, 0);
        send_tick(65535, 1'b1, 12, -12);
        send_tick(0, 1'b1, 32767, -32768);
        send_tick(0, 1'b1, -32768, 32767);
        send_tick(0, 1'b0, 0, 0);
        drain();

        run_hops(130);
        drain();

        // Every register at its maximum: the widest products and saturated
        // hip torques.
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_hops(110);
        drain();

        // Every register at zero: threshold at zero length and no force or
        // torque contribution.
        load_config('0, '0, '0, '0, '0, '0);
        run_hops(90);
        drain();

        // Fully random settings, then writes to the two spare indexes, which
        // must change nothing.
        load_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        write_reg(REG_SPARE_LO, 16'($urandom_range(0, 65535)));
        write_reg(REG_SPARE_HI, 16'($urandom_range(0, 65535)));
        run_hops(120);
        drain();

        // A plausible leg with a very strong rate gain, so that the rate term
        // alone drives the torques into saturation.
        load_config(16'($urandom_range(2000, 8000)), 16'($urandom_range(30000, 65535)),
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 4096)), 16'hFFFF);
        run_hops(120);
        drain();

        load_config(REST_LENGTH_RST, THRESHOLD_FRAC_RST, SPRING_STIFF_RST,
                    THRUST_FORCE_RST, POSE_GAIN_P_RST, POSE_GAIN_V_RST);
        run_hops(110);

        // Let the last results drain and keep the clock running so that any
        // stray result still shows.
        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
